@@ src/tw_odo_pkg.sv @@
// ----------------------------------------------------------------------------
// tw_odo_pkg
// Shared types and constants for the three-wheel odometry tracker.
// ----------------------------------------------------------------------------
package tw_odo_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int ANGLE_W      = 32;
    localparam int TRIG_W       = 35;   // signed Q1.30 sin/cos with headroom
    localparam int MUL_A_W      = 64;
    localparam int MUL_B_W      = 32;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;

    localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;

    // configuration register indexes
    localparam logic [1:0] REG_TRAVEL = 2'd0;
    localparam logic [1:0] REG_TURNS  = 2'd1;
    localparam logic [1:0] REG_ARM    = 2'd2;

    // request into the shared multiplier
    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a_mag;
        logic [MUL_B_W-1:0] b_mag;
    } mul_req_t;

    // arctangent of 2^-i in binary angle units (one turn = 2^32)
    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ src/tw_odo_mul.sv @@
// ----------------------------------------------------------------------------
// tw_odo_mul
// Shared unsigned multiplier: 64 x 32 product built from two 32 x 32 passes.
// ----------------------------------------------------------------------------
module tw_odo_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tw_odo_pkg::mul_req_t          req,
    output logic                          done,
    output logic [tw_odo_pkg::PROD_W-1:0] prod
);
    import tw_odo_pkg::*;

    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic               busy_reg;
    logic               phase_reg;
    logic               done_reg;
    logic [63:0]        part;

    // one 32 x 32 multiplier, low half first then high half
    assign part = (phase_reg ? a_reg[63:32] : a_reg[31:0]) * b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (phase_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                phase_reg <= ~phase_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a_mag;
            b_reg <= req.b_mag;
        end
        else if (busy_reg)
        begin
            if (phase_reg)
                acc_reg <= acc_reg + {part, 32'd0};
            else
                acc_reg <= {32'd0, part};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ src/tw_odo_cordic.sv @@
// ----------------------------------------------------------------------------
// tw_odo_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, gives cos and sin Q1.30.
// ----------------------------------------------------------------------------
module tw_odo_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [tw_odo_pkg::ANGLE_W-1:0]       angle,
    output logic                                 done,
    output logic signed [tw_odo_pkg::TRIG_W-1:0] cos_q,
    output logic signed [tw_odo_pkg::TRIG_W-1:0] sin_q
);
    import tw_odo_pkg::*;

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               flip_reg;

    logic               flip_in;
    logic [31:0]        a_in;
    logic signed [33:0] dx, dy, atan_s;

    // fold the angle into the right half plane
    assign flip_in = angle[31] ^ angle[30];
    assign a_in    = flip_in ? (angle - 32'h80000000) : angle;

    assign dx     = y_reg >>> step_reg;
    assign dy     = x_reg >>> step_reg;
    assign atan_s = $signed({2'b00, atan_turns(5'(step_reg))});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    // micro-rotation datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= $signed(CORDIC_GAIN_Q30);
            y_reg    <= '0;
            z_reg    <= $signed({{2{a_in[31]}}, a_in});
            flip_reg <= flip_in;
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_s;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_s;
            end
        end
    end

    assign done  = done_reg;
    assign cos_q = flip_reg ? -TRIG_W'(x_reg) : TRIG_W'(x_reg);
    assign sin_q = flip_reg ? -TRIG_W'(y_reg) : TRIG_W'(y_reg);

endmodule

@@ src/three_wheel_odometry.sv @@
// ----------------------------------------------------------------------------
// three_wheel_odometry
// Dead-reckoning pose tracker from three tracking-wheel encoder samples.
// Per sample, from transfer to m_tvalid: nine passes through the shared
// multiplier, with the CORDIC run after the fifth, then the pose update and
// the output reg. Samples are handled one at a time: a new sample is taken
// once the sequencer is idle, even while the previous result waits in the
// output reg.
// Reset: counts, heading and position clear; registers take their defaults.
// ----------------------------------------------------------------------------
module three_wheel_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // left_count, right_count, center_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // x_pos, y_pos, heading_code
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tw_odo_pkg::*;

    typedef enum logic [3:0] {
        OP_TL, OP_TR, OP_TC, OP_DH, OP_ARM, OP_P1, OP_P2, OP_P3, OP_P4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_CORDIC, ST_POSE1, ST_POSE2, ST_OUT
    } state_t;

    state_t state_reg;
    op_t    op_reg;

    // configuration
    logic [23:0] travel_reg, arm_reg;
    logic [31:0] turns_reg;

    // pose state
    logic signed [23:0] prev_l_reg, prev_r_reg, prev_c_reg;
    logic [31:0]        heading_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;

    // per-sample working values
    logic signed [24:0] dl_reg, dr_reg, dc_reg;
    logic signed [48:0] tl_reg, tr_reg, tc_reg, fwd_reg;
    logic signed [57:0] dh_reg;
    logic signed [58:0] strafe_reg;
    logic signed [60:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [53:0] dx_reg, dy_reg;

    // output register
    logic        out_valid_reg;
    logic [79:0] out_data_reg;

    // shared units
    mul_req_t                    mreq;
    logic                        mul_done, cordic_done, cordic_start;
    logic [PROD_W-1:0]           prod;
    logic signed [TRIG_W-1:0]    cos_q, sin_q;

    // input fields
    logic signed [23:0] in_l, in_r, in_c;
    assign in_l = s_tdata[23:0];
    assign in_r = s_tdata[47:24];
    assign in_c = s_tdata[71:48];

    // operand selection for the current op
    logic signed [63:0] opa, opa_abs;
    logic signed [35:0] opb, opb_abs;
    logic [4:0]         shamt;
    logic               neg;
    logic signed [49:0] t_diff;

    assign t_diff = 50'(tl_reg) - 50'(tr_reg);

    always_comb
    begin
        unique case (op_reg)
            OP_TL:   begin opa = 64'(dl_reg);     opb = 36'(travel_reg);  shamt = 5'd0;  end
            OP_TR:   begin opa = 64'(dr_reg);     opb = 36'(travel_reg);  shamt = 5'd0;  end
            OP_TC:   begin opa = 64'(dc_reg);     opb = 36'(travel_reg);  shamt = 5'd0;  end
            OP_DH:   begin opa = 64'(t_diff);     opb = 36'(turns_reg);   shamt = 5'd24; end
            OP_ARM:  begin opa = 64'(dh_reg);     opb = 36'(arm_reg);     shamt = 5'd24; end
            OP_P1:   begin opa = 64'(fwd_reg);    opb = 36'(cos_q);       shamt = 5'd30; end
            OP_P2:   begin opa = 64'(strafe_reg); opb = 36'(sin_q);       shamt = 5'd30; end
            OP_P3:   begin opa = 64'(fwd_reg);    opb = 36'(sin_q);       shamt = 5'd30; end
            OP_P4:   begin opa = 64'(strafe_reg); opb = 36'(cos_q);       shamt = 5'd30; end
            default: begin opa = '0;              opb = '0;               shamt = 5'd0;  end
        endcase
    end

    // sign-magnitude operands; the sign of the product is kept aside
    assign opa_abs = opa[63] ? -opa : opa;
    assign opb_abs = opb[35] ? -opb : opb;
    assign neg     = opa[63] ^ opb[35];

    logic neg_reg;
    logic [4:0] shamt_reg;

    assign mreq.start = (state_reg == ST_MUL_GO);
    assign mreq.a_mag = opa_abs;
    assign mreq.b_mag = opb_abs[31:0];

    tw_odo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .done  (mul_done),
        .prod  (prod)
    );

    tw_odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (heading_reg),
        .done  (cordic_done),
        .cos_q (cos_q),
        .sin_q (sin_q)
    );

    // scaled product, truncated toward zero
    logic [PROD_W-1:0]  prod_sh;
    logic signed [63:0] res;
    assign prod_sh = prod >> shamt_reg;
    assign res     = neg_reg ? -$signed({1'b0, prod_sh[62:0]}) : $signed({1'b0, prod_sh[62:0]});

    // pose motion helpers
    logic signed [49:0] t_sum;
    logic signed [61:0] mx, my;
    logic signed [55:0] sum_x, sum_y;
    assign t_sum = 50'(tl_reg) + 50'(tr_reg);
    assign mx    = 62'(p1_reg) - 62'(p2_reg);
    assign my    = 62'(p3_reg) + 62'(p4_reg);
    assign sum_x = 56'(pos_x_reg) + 56'(dx_reg);
    assign sum_y = 56'(pos_y_reg) + 56'(dy_reg);

    function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
        logic signed [31:0] r;
        if (v > 56'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -56'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    assign cordic_start = (state_reg == ST_MUL_WAIT) && mul_done && (op_reg == OP_ARM);

    // sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_TL;
            out_valid_reg <= 1'b0;
            travel_reg    <= 24'd408479;
            turns_reg     <= 32'd85659860;
            arm_reg       <= 24'd2676546;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            prev_c_reg    <= '0;
            heading_reg   <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TRAVEL: travel_reg <= cfg_data[23:0];
                    REG_TURNS:  turns_reg  <= cfg_data;
                    REG_ARM:    arm_reg    <= cfg_data[23:0];
                    default:    ;
                endcase
            end

            // drain the output reg; the last state reloads it itself
            if (m_tvalid && m_tready && (state_reg != ST_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        prev_l_reg <= in_l;
                        prev_r_reg <= in_r;
                        prev_c_reg <= in_c;
                        op_reg     <= OP_TL;
                        state_reg  <= ST_MUL_GO;
                    end
                end
                ST_MUL_GO:
                begin
                    state_reg <= ST_MUL_WAIT;
                end
                ST_MUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        unique case (op_reg)
                            OP_TL:  begin op_reg <= OP_TR;  state_reg <= ST_MUL_GO; end
                            OP_TR:  begin op_reg <= OP_TC;  state_reg <= ST_MUL_GO; end
                            OP_TC:  begin op_reg <= OP_DH;  state_reg <= ST_MUL_GO; end
                            OP_DH:
                            begin
                                heading_reg <= heading_reg + res[31:0];
                                op_reg      <= OP_ARM;
                                state_reg   <= ST_MUL_GO;
                            end
                            OP_ARM: state_reg <= ST_CORDIC;
                            OP_P1:  begin op_reg <= OP_P2;  state_reg <= ST_MUL_GO; end
                            OP_P2:  begin op_reg <= OP_P3;  state_reg <= ST_MUL_GO; end
                            OP_P3:  begin op_reg <= OP_P4;  state_reg <= ST_MUL_GO; end
                            OP_P4:  state_reg <= ST_POSE1;
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_CORDIC:
                begin
                    if (cordic_done)
                    begin
                        op_reg    <= OP_P1;
                        state_reg <= ST_MUL_GO;
                    end
                end
                ST_POSE1:
                begin
                    state_reg <= ST_POSE2;
                end
                ST_POSE2:
                begin
                    pos_x_reg <= sat32(sum_x);
                    pos_y_reg <= sat32(sum_y);
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // working datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            dl_reg <= 25'(in_l) - 25'(prev_l_reg);
            dr_reg <= 25'(in_r) - 25'(prev_r_reg);
            dc_reg <= 25'(in_c) - 25'(prev_c_reg);
        end
        if (state_reg == ST_MUL_GO)
        begin
            neg_reg   <= neg;
            shamt_reg <= shamt;
        end
        if (state_reg == ST_MUL_WAIT && mul_done)
        begin
            unique case (op_reg)
                OP_TL:  tl_reg <= res[48:0];
                OP_TR:  tr_reg <= res[48:0];
                OP_TC:
                begin
                    tc_reg  <= res[48:0];
                    // forward travel, halved toward zero
                    fwd_reg <= 49'((t_sum + 50'(t_sum[49])) >>> 1);
                end
                OP_DH:  dh_reg <= res[57:0];
                OP_ARM: strafe_reg <= 59'(tc_reg) - res[58:0];
                OP_P1:  p1_reg <= res[60:0];
                OP_P2:  p2_reg <= res[60:0];
                OP_P3:  p3_reg <= res[60:0];
                OP_P4:  p4_reg <= res[60:0];
                default: ;
            endcase
        end
        if (state_reg == ST_POSE1)
        begin
            // Q.24 to Q16.16, toward zero
            dx_reg <= 54'((mx + (mx[61] ? 62'sd255 : 62'sd0)) >>> 8);
            dy_reg <= 54'((my + (my[61] ? 62'sd255 : 62'sd0)) >>> 8);
        end
        if (state_reg == ST_OUT && (!out_valid_reg || m_tready))
        begin
            out_data_reg <= {16'((32'd0 - heading_reg) >> 16), pos_y_reg, pos_x_reg};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // a sample moves the sequencer out of idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL_GO))
        else $error("sequencer did not start on accepted sample");

    // multiplier completes only while the sequencer waits for it
    a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL_WAIT))
        else $error("multiplier done outside wait state");

    // cordic completes only while the sequencer waits for it
    a_cordic_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> (state_reg == ST_CORDIC))
        else $error("cordic done outside wait state");

    // a new result is only loaded when the output register is free or drained
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && m_tvalid && !m_tready) |=> (state_reg == ST_OUT))
        else $error("result overwritten while stalled");

endmodule

@@ test/odometry_checker.sv @@
// ----------------------------------------------------------------------------
// odometry_checker
// Watches the sample and pose streams of the odometry tracker, predicts each
// pose from its own copy of counts, heading, position and registers, and
// compares every pose transfer field by field.
// ----------------------------------------------------------------------------
module odometry_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          poses_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tw_odo_pkg::*;

    typedef struct packed {
        logic [15:0] heading_code;
        logic [31:0] y_pos;
        logic [31:0] x_pos;
    } pose_t;

    // tracker model state
    logic [23:0] travel_per_degree;
    logic [31:0] turns_per_inch;
    logic [23:0] center_arm;
    longint      last_left, last_right, last_center;
    logic [31:0] heading;
    longint      px, py;
    pose_t       pose_queue[$];

    // floor shift
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // a * b / 2^s, truncated toward zero, 128-bit intermediate
    function automatic longint mul_trunc(longint a, longint b, int s);
        logic [127:0] ma, mb, p;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? 128'(-a) : 128'(a);
        mb  = (b < 0) ? 128'(-b) : 128'(b);
        p   = (ma * mb) >> s;
        p[127:63] = '0;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // rotation-mode CORDIC, Q1.30, with half-turn fold
    task automatic heading_trig(input logic [31:0] ang, output longint c, output longint s);
        logic        flip;
        logic [31:0] a;
        longint      z, x, y, dx, dy;
        int          n;
        flip = ang[31] ^ ang[30];
        a    = flip ? ang - 32'h80000000 : ang;
        z    = longint'(signed'(a));
        x    = longint'(CORDIC_GAIN_Q30);
        y    = 0;
        n    = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
        for (int i = 0; i < n; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_turns(5'(i)));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_turns(5'(i)));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // advance the pose by one sample
    task automatic track_sample(input logic [71:0] d);
        longint l, r, ce, dl, dr, dc, tp, dh, fwd, strafe, c, s, mx, my;
        pose_t  p;
        l  = longint'(signed'(d[23:0]));
        r  = longint'(signed'(d[47:24]));
        ce = longint'(signed'(d[71:48]));
        dl = l - last_left;
        dr = r - last_right;
        dc = ce - last_center;
        tp = longint'(travel_per_degree);
        dh = mul_trunc((dl - dr) * tp, longint'(turns_per_inch), 24);
        fwd = (dl * tp + dr * tp) / 2;
        strafe = dc * tp - mul_trunc(dh, longint'(center_arm), 24);
        last_left = l; last_right = r; last_center = ce;
        heading = heading + dh[31:0];
        heading_trig(heading, c, s);
        mx = mul_trunc(fwd, c, 30) - mul_trunc(strafe, s, 30);
        my = mul_trunc(fwd, s, 30) + mul_trunc(strafe, c, 30);
        px = clamp32(px + mx / 256);
        py = clamp32(py + my / 256);
        p.x_pos = px[31:0];
        p.y_pos = py[31:0];
        p.heading_code = 16'((32'd0 - heading) >> 16);
        pose_queue.push_back(p);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pose_t exp_p, act_p;
        if (!rst_n)
        begin
            travel_per_degree = 24'd408479;
            turns_per_inch    = 32'd85659860;
            center_arm        = 24'd2676546;
            last_left = 0; last_right = 0; last_center = 0;
            heading = '0; px = 0; py = 0;
            pose_queue.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TRAVEL: travel_per_degree = cfg_data[23:0];
                    REG_TURNS:  turns_per_inch = cfg_data;
                    REG_ARM:    center_arm = cfg_data[23:0];
                    default: ;
                endcase
            end
            // pose transfer
            if (m_tvalid && m_tready)
            begin
                act_p = m_tdata;
                if (pose_queue.size() == 0)
                begin
                    $error("pose transfer with no sample pending: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_p = pose_queue.pop_front();
                    if (act_p.x_pos !== exp_p.x_pos)
                    begin
                        $error("x_pos expected %0d actual %0d",
                               signed'(exp_p.x_pos), signed'(act_p.x_pos));
                        fail_count++;
                    end
                    if (act_p.y_pos !== exp_p.y_pos)
                    begin
                        $error("y_pos expected %0d actual %0d",
                               signed'(exp_p.y_pos), signed'(act_p.y_pos));
                        fail_count++;
                    end
                    if (act_p.heading_code !== exp_p.heading_code)
                    begin
                        $error("heading_code expected %0d actual %0d",
                               exp_p.heading_code, act_p.heading_code);
                        fail_count++;
                    end
                end
            end
            // sample transfer
            if (s_tvalid && s_tready)
                track_sample(s_tdata);
        end
        poses_pending = pose_queue.size();
    end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Encoder sample stimulus for the three-wheel odometry tracker: directed
// extremes, smooth random motion and raw jumps, under several register
// settings, with random stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tw_odo_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;   // index past the register list
    localparam int         DRAIN      = 80;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          poses_pending;
    bit          quiet;
    bit          hold_off;
    logic [23:0] cur_l, cur_r, cur_c;

    three_wheel_odometry i_dut (.*);

    odometry_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // pose sink with random stalls and one long hold-off
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 11);
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // drives at the falling edge, so back-to-back calls just overwrite valid
    task automatic send_sample(input logic [23:0] l, input logic [23:0] r,
                               input logic [23:0] c);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 11);
            s_tvalid = 1'b0;
            repeat (n) @(negedge clk);
        end
        s_tdata  = {c, r, l};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
        cur_l = l; cur_r = r; cur_c = c;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic settle();
        while (poses_pending != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // mostly smooth wheel motion, some raw jumps
    task automatic random_run(input int count);
        int step;
        for (int i = 0; i < count; i++)
        begin
            step = $urandom_range(0, 9);
            if (step == 0)
                send_sample(24'($urandom), 24'($urandom), 24'($urandom));
            else
                send_sample(cur_l + 24'($urandom_range(0, 800) - 400),
                            cur_r + 24'($urandom_range(0, 800) - 400),
                            cur_c + 24'($urandom_range(0, 200) - 100));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        hold_off = 1'b0;
        cur_l = '0; cur_r = '0; cur_c = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, wraps, straight and spin moves
        send_sample(24'h7FFFFF, 24'h800000, 24'h000000);
        send_sample(24'h800000, 24'h7FFFFF, 24'h7FFFFF);
        send_sample(24'h800000, 24'h800000, 24'h800000);
        send_sample(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_sample(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_sample(24'h000000, 24'h000000, 24'h000000);
        send_sample(24'hFFFFFF, 24'h000001, 24'h555555);
        send_sample(24'h000001, 24'hFFFFFF, 24'hAAAAAA);
        for (int i = 0; i < 8; i++)
            send_sample(cur_l + 24'd1000, cur_r - 24'd1000, cur_c);
        settle();

        // saturate position: max scaling, long straight runs
        write_reg(REG_TRAVEL, 32'hFFFFFF);
        write_reg(REG_TURNS, 32'h0);
        write_reg(REG_ARM, 32'hFFFFFF);
        for (int i = 0; i < 6; i++)
            send_sample(cur_l ^ 24'h800000, cur_r ^ 24'h800000, cur_c ^ 24'hFFFFFF);
        for (int i = 0; i < 6; i++)
            send_sample(24'h7FFFFF - cur_l, 24'h7FFFFF - cur_r, cur_c);
        random_run(300);
        settle();

        // long output hold-off while samples keep coming
        write_reg(REG_TURNS, 32'hFFFFFFFF);
        write_reg(REG_TRAVEL, 32'h0);
        write_reg(REG_ARM, 32'h0);
        write_reg(REG_UNUSED, 32'h12345678);
        hold_off = 1'b1;
        random_run(200);
        settle();

        // random register settings
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_TRAVEL, $urandom_range(0, 24'hFFFFFF));
            write_reg(REG_TURNS, $urandom);
            write_reg(REG_ARM, $urandom_range(0, 24'hFFFFFF));
            random_run(250);
            settle();
        end

        // defaults, no idling at the end
        write_reg(REG_TRAVEL, 32'd408479);
        write_reg(REG_TURNS, 32'd85659860);
        write_reg(REG_ARM, 32'd2676546);
        random_run(200);
        quiet = 1'b1;
        random_run(300);
        settle();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/tw_odo_pkg.sv
src/tw_odo_mul.sv
src/tw_odo_cordic.sv
src/three_wheel_odometry.sv
test/odometry_checker.sv
test/testbench.sv
